@@ design/dobft_pkg.sv @@
// Shared types and constants for the dual-offset binned flash trigger.
// Used by the serial divider and by the top level; depends on nothing else.
package dobft_pkg;

   // field widths of the pulse and result transactions
   localparam int SLICE_W    = 20;
   localparam int TICK_W     = 12;
   localparam int AMP_W      = 16;
   localparam int SPE_W      = 16;
   localparam int TIME_W     = 21;
   localparam int BIN_OUT_W  = 10;
   localparam int TOTAL_W    = 32;

   // configuration register widths and reset values
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int BW_W       = 16;
   localparam logic [AMP_W-1:0]   HIT_THR_RESET   = AMP_W'(0);
   localparam logic [BW_W-1:0]    BIN_WIDTH_RESET = BW_W'(16);
   localparam logic [TOTAL_W-1:0] FLASH_THR_RESET = TOTAL_W'(512);

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_THRESHOLD   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_THRESHOLD = CSR_IDX_W'(2);

   // transaction action and histogram select codes
   localparam logic ACT_PULSE   = 1'b0;
   localparam logic ACT_CLEAR   = 1'b1;
   localparam logic SEL_ALIGNED = 1'b0;
   localparam logic SEL_SHIFTED = 1'b1;

   // charge scaling: peak * 4096 gives 1/256 pe with spe in 1/16 counts
   localparam int PE_SHIFT   = 12;

   // wide enough for (slice + tick + bin_width/2) / 1
   localparam int IDX_W      = 22;

   localparam int NUM_BINS_DEFAULT = 1024;

   // shared divider: two quotient bits per cycle
   localparam int DIVIDEND_W     = AMP_W + PE_SHIFT;
   localparam int DIVISOR_W      = 16;
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STEPS      = DIVIDEND_W / DIV_RADIX_BITS;
   localparam int STEP_CNT_W     = $clog2(DIV_STEPS);

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

endpackage

@@ design/dobft_div.sv @@
// Iterative restoring divider, two quotient bits per clock.
// Depends on dobft_pkg for widths and the request and response structs.
module dobft_div
   import dobft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] count_ff, count_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] quo_step;
   logic [DIVISOR_W-1:0]  rem_step;

   // two dependent shift-subtract steps
   always_comb begin
      logic [DIVISOR_W:0]    trial;
      logic [DIVIDEND_W-1:0] quo_v;
      logic [DIVISOR_W-1:0]  rem_v;
      quo_v = quo_ff;
      rem_v = rem_ff;
      trial = '0;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         trial = {rem_v, quo_v[DIVIDEND_W-1]};
         quo_v = {quo_v[DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial    = trial - {1'b0, dvs_ff};
            quo_v[0] = 1'b1;
         end
         rem_v = trial[DIVISOR_W-1:0];
      end
      quo_step = quo_v;
      rem_step = rem_v;
   end

   // next-state selection
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = div_req.dividend;
         rem_in   = '0;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         quo_in   = quo_step;
         rem_in   = rem_step;
         count_in = count_ff + STEP_CNT_W'(1);
         if (count_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

@@ design/dual_offset_binned_flash_trigger_top.sv @@
// Top level of the dual-offset binned flash trigger: sequencer, bin memories
// and result register. Depends on dobft_pkg and dobft_div.
//
// Pulse transactions arrive on req_* (valid/stall). A clear transaction empties
// both histograms; a pulse below hit_threshold is dropped; any other pulse has
// its charge (peak*4096/spe) and its bin index worked out on one shared serial
// divider, then both bins are read, updated with saturation and written back.
// Each bin that reaches flash_threshold gives one result transaction on rsp_*,
// aligned bin first, shifted bin second, last_of_run on the final one.
// A kept pulse occupies the block from the accept cycle through two divisions
// on the shared divider (each a load plus 14 two-bit steps), a memory read,
// an update and the two emit steps; no new pulse is taken until it is done.
// A dropped pulse is taken without leaving the idle state.
// A clear transaction holds req_stall high while the sweep writes one entry of
// each memory per cycle; the same sweep runs after reset, so the block accepts
// no pulse after reset is released until that sweep has run through.
// Configuration writes on csr_* are always taken (csr_ready is high).
// A stalled receiver leaves the result in the output register; a later pulse
// whose result finds it full waits in its emit step with req_stall held high.
module dual_offset_binned_flash_trigger_top
   import dobft_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [SLICE_W-1:0]    req_time_slice,
   input  logic [TICK_W-1:0]     req_pulse_peak_tick,
   input  logic [AMP_W-1:0]      req_peak_amplitude,
   input  logic [SPE_W-1:0]      req_spe_size,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accumulator_sel,
   output logic [BIN_OUT_W-1:0]  rsp_bin_index,
   output logic [TOTAL_W-1:0]    rsp_bin_total,
   output logic                  rsp_last_of_run,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(NUM_BINS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DIV_PE, S_DIV_BIN, S_READ, S_UPDATE, S_EMIT_A, S_EMIT_S
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [TIME_W-1:0]     t_ff, t_in;
   logic [DIVIDEND_W-1:0] pe_ff, pe_in;
   logic [IDX_W-1:0]      a_idx_ff, a_idx_in;
   logic [IDX_W-1:0]      s_idx_ff, s_idx_in;
   logic [TOTAL_W-1:0]    a_new_ff, a_new_in;
   logic [TOTAL_W-1:0]    s_new_ff, s_new_in;
   logic                  cross_a_ff, cross_a_in;
   logic                  cross_s_ff, cross_s_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_sel_ff, rsp_sel_in;
   logic [BIN_OUT_W-1:0]  rsp_bin_ff, rsp_bin_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [AMP_W-1:0]      hit_thr_ff;
   logic [BW_W-1:0]       bin_width_ff;
   logic [TOTAL_W-1:0]    flash_thr_ff;

   logic [TOTAL_W-1:0]    aligned_mem [NUM_BINS];
   logic [TOTAL_W-1:0]    shifted_mem [NUM_BINS];
   logic [TOTAL_W-1:0]    a_rd_ff, s_rd_ff;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic [SPE_W-1:0]      spe_eff;
   logic [BW_W-1:0]       bw_eff;
   logic                  a_ok, s_ok;
   logic                  out_free;
   logic                  sweeping;
   logic                  a_we, s_we, mem_re;
   logic [ADDR_W-1:0]     a_waddr, s_waddr;
   logic [TOTAL_W-1:0]    a_wdata, s_wdata;
   logic [TOTAL_W:0]      a_sum, s_sum;
   logic [TOTAL_W-1:0]    a_sat, s_sat;
   logic                  bump;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_thr_ff   <= HIT_THR_RESET;
         bin_width_ff <= BIN_WIDTH_RESET;
         flash_thr_ff <= FLASH_THR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HIT_THRESHOLD:   hit_thr_ff   <= csr_data[AMP_W-1:0];
            CSR_BIN_WIDTH:       bin_width_ff <= csr_data[BW_W-1:0];
            CSR_FLASH_THRESHOLD: flash_thr_ff <= csr_data[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // zero spe and zero bin width count as one
   assign spe_eff = (req_spe_size == '0) ? SPE_W'(1) : req_spe_size;
   assign bw_eff  = (bin_width_ff == '0) ? BW_W'(1) : bin_width_ff;

   // bins outside the store are skipped
   assign a_ok = a_idx_ff < IDX_W'(NUM_BINS);
   assign s_ok = s_idx_ff < IDX_W'(NUM_BINS);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // saturating bin update from the registered read data
   assign a_sum = {1'b0, a_rd_ff} + (TOTAL_W + 1)'(pe_ff);
   assign s_sum = {1'b0, s_rd_ff} + (TOTAL_W + 1)'(pe_ff);
   assign a_sat = a_sum[TOTAL_W] ? '1 : a_sum[TOTAL_W-1:0];
   assign s_sat = s_sum[TOTAL_W] ? '1 : s_sum[TOTAL_W-1:0];

   // shifted bin is one higher when remainder plus half width reaches a width
   assign bump = ({1'b0, div_rsp.remainder} + {2'b00, bw_eff[BW_W-1:1]})
                 >= {1'b0, bw_eff};

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      t_in         = t_ff;
      pe_in        = pe_ff;
      a_idx_in     = a_idx_ff;
      s_idx_in     = s_idx_ff;
      a_new_in     = a_new_ff;
      s_new_in     = s_new_ff;
      cross_a_in   = cross_a_ff;
      cross_s_in   = cross_s_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sel_in   = rsp_sel_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      div_req      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(NUM_BINS - 1)) begin
               clr_addr_in = '0;
               state_in    = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_CLEAR) begin
                  clr_addr_in = '0;
                  state_in    = S_CLEAR;
               end else if (req_peak_amplitude >= hit_thr_ff) begin
                  t_in             = TIME_W'(req_time_slice) + TIME_W'(req_pulse_peak_tick);
                  div_req.start    = 1'b1;
                  div_req.dividend = {req_peak_amplitude, PE_SHIFT'(0)};
                  div_req.divisor  = spe_eff;
                  state_in         = S_DIV_PE;
               end
            end
         end
         S_DIV_PE: begin
            if (div_rsp.done) begin
               pe_in            = div_rsp.quotient;
               div_req.start    = 1'b1;
               div_req.dividend = DIVIDEND_W'(t_ff);
               div_req.divisor  = bw_eff;
               state_in         = S_DIV_BIN;
            end
         end
         S_DIV_BIN: begin
            if (div_rsp.done) begin
               a_idx_in = div_rsp.quotient[IDX_W-1:0];
               s_idx_in = div_rsp.quotient[IDX_W-1:0] + IDX_W'(bump);
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            a_new_in   = a_sat;
            s_new_in   = s_sat;
            cross_a_in = a_ok && (a_sat >= flash_thr_ff) && (a_rd_ff < flash_thr_ff);
            cross_s_in = s_ok && (s_sat >= flash_thr_ff) && (s_rd_ff < flash_thr_ff);
            state_in   = S_EMIT_A;
         end
         S_EMIT_A: begin
            if (!cross_a_ff) begin
               state_in = S_EMIT_S;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sel_in   = SEL_ALIGNED;
               rsp_bin_in   = a_idx_ff[BIN_OUT_W-1:0];
               rsp_total_in = a_new_ff;
               rsp_last_in  = !cross_s_ff;
               state_in     = S_EMIT_S;
            end
         end
         S_EMIT_S: begin
            if (!cross_s_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sel_in   = SEL_SHIFTED;
               rsp_bin_in   = s_idx_ff[BIN_OUT_W-1:0];
               rsp_total_in = s_new_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff         <= t_in;
      pe_ff        <= pe_in;
      a_idx_ff     <= a_idx_in;
      s_idx_ff     <= s_idx_in;
      a_new_ff     <= a_new_in;
      s_new_ff     <= s_new_in;
      cross_a_ff   <= cross_a_in;
      cross_s_ff   <= cross_s_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   dobft_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // memory port control: sweep writes zero, update writes the new totals
   assign sweeping = (state_ff == S_CLEAR);
   assign mem_re   = (state_ff == S_READ);
   assign a_we     = sweeping || ((state_ff == S_UPDATE) && a_ok);
   assign s_we     = sweeping || ((state_ff == S_UPDATE) && s_ok);
   assign a_waddr  = sweeping ? clr_addr_ff : a_idx_ff[ADDR_W-1:0];
   assign s_waddr  = sweeping ? clr_addr_ff : s_idx_ff[ADDR_W-1:0];
   assign a_wdata  = sweeping ? '0 : a_sat;
   assign s_wdata  = sweeping ? '0 : s_sat;

   // aligned histogram memory
   always_ff @(posedge clock) begin
      if (a_we) begin
         aligned_mem[a_waddr] <= a_wdata;
      end
      if (mem_re && a_ok) begin
         a_rd_ff <= aligned_mem[a_idx_ff[ADDR_W-1:0]];
      end
   end

   // half-bin shifted histogram memory
   always_ff @(posedge clock) begin
      if (s_we) begin
         shifted_mem[s_waddr] <= s_wdata;
      end
      if (mem_re && s_ok) begin
         s_rd_ff <= shifted_mem[s_idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accumulator_sel = rsp_sel_ff;
   assign rsp_bin_index       = rsp_bin_ff;
   assign rsp_bin_total       = rsp_total_ff;
   assign rsp_last_of_run     = rsp_last_ff;

`ifndef SYNTHESIS
   // the divider only finishes while the sequencer waits for it
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_PE) || (state_ff == S_DIV_BIN))
      else $error("divider finished outside a division wait");

   // every result holds a total at or above a non-zero flash threshold
   a_result_crossed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_total_ff >= flash_thr_ff) && (flash_thr_ff != '0))
      else $error("result below flash threshold");

   // leaving reset always starts the clearing sweep
   a_reset_sweep: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == S_CLEAR) && (clr_addr_ff == '0))
      else $error("no clearing sweep after reset");

   // a second result of one pulse follows only a first that was not last
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_S) && cross_s_ff && cross_a_ff |-> !rsp_last_ff || !rsp_valid_ff
      || rsp_sel_ff)
      else $error("aligned result marked last before a shifted result");
`endif

endmodule
